// File: rtl/scb_pkg.sv
package scb_pkg;
  localparam int DivW = 32;
  localparam int QW = 16;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_EMPTY = 3'd1,
    ST_CROP = 3'd2,
    ST_DEST = 3'd3,
    ST_OFFSET = 3'd4
  } status_t;

  localparam logic [2:0] REG_SRC_COMP = 3'd0;
  localparam logic [2:0] REG_DST_COMP = 3'd1;
  localparam logic [2:0] REG_SRC_SIZE = 3'd2;
  localparam logic [2:0] REG_DST_SIZE = 3'd3;
  localparam logic [2:0] REG_CROP_ORG = 3'd4;
  localparam logic [2:0] REG_CROP_EXT = 3'd5;
  localparam logic [2:0] REG_DST_ORG = 3'd6;
  localparam logic [2:0] REG_DST_EXT = 3'd7;

  function automatic logic [2:0] clamp_comp(input logic [2:0] c);
    if (c == 3'd0) return 3'd1;
    if (c > 3'd4) return 3'd4;
    return c;
  endfunction
endpackage

// File: rtl/scb_if.sv
interface scb_in_if;
  logic valid;
  logic ready;
  logic action;
  logic [15:0] load_index;
  logic [31:0] load_pixel;
  logic [15:0] offset_x;
  logic [15:0] offset_y;
  modport source(output valid, action, load_index, load_pixel, offset_x, offset_y,
                 input ready);
  modport sink(input valid, action, load_index, load_pixel, offset_x, offset_y,
               output ready);
endinterface

interface scb_out_if;
  logic valid;
  logic ready;
  logic [31:0] dest_index;
  logic [31:0] dest_pixel;
  logic [2:0] byte_count;
  logic [2:0] status;
  modport source(output valid, dest_index, dest_pixel, byte_count, status,
                 input ready);
  modport sink(input valid, dest_index, dest_pixel, byte_count, status,
               output ready);
endinterface

// File: rtl/scaled_crop_blit.sv
// Nearest-neighbor scaled, cropped blit. Every item (a pixel load or a blit)
// gives exactly one result word, and one item is taken per clock when the
// output side keeps up. A front stage checks the rectangles, then a 16-stage
// pipelined restoring divider maps x and y into the crop, an address stage
// multiplies the row by the source width, a registered read of the pixel
// store follows, and a final stage converts the pixel format. The pipeline
// stalls as a whole when the output register is full and not taken; a 2-deep
// skid buffer lets input stay ready meanwhile. Loads write the store at the
// write stage in order, so a blit always sees every earlier load. The user
// must configure over the APB-style port while idle; it is not enforced.
module scaled_crop_blit
  import scb_pkg::*;
#(
  parameter int SOURCE_PIXELS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  scb_in_if.sink      in_ch,
  scb_out_if.source   out_ch
);
  localparam int AW = (SOURCE_PIXELS > 1) ? $clog2(SOURCE_PIXELS) : 1;
  localparam int NS = QW;           // divider stages

  // configuration registers
  logic [2:0]  src_comp, dst_comp;
  logic [31:0] src_size, dst_size, crop_org, crop_ext, dst_org, dst_ext;
  logic [2:0]  reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_comp <= 3'd4;
      dst_comp <= 3'd4;
      src_size <= '0;
      dst_size <= '0;
      crop_org <= '0;
      crop_ext <= '0;
      dst_org <= '0;
      dst_ext <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_SRC_COMP: src_comp <= pwdata[2:0];
        REG_DST_COMP: dst_comp <= pwdata[2:0];
        REG_SRC_SIZE: src_size <= pwdata;
        REG_DST_SIZE: dst_size <= pwdata;
        REG_CROP_ORG: crop_org <= pwdata;
        REG_CROP_EXT: crop_ext <= pwdata;
        REG_DST_ORG:  dst_org <= pwdata;
        REG_DST_EXT:  dst_ext <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SRC_COMP: prdata = {29'd0, src_comp};
      REG_DST_COMP: prdata = {29'd0, dst_comp};
      REG_SRC_SIZE: prdata = src_size;
      REG_DST_SIZE: prdata = dst_size;
      REG_CROP_ORG: prdata = crop_org;
      REG_CROP_EXT: prdata = crop_ext;
      REG_DST_ORG:  prdata = dst_org;
      REG_DST_EXT:  prdata = dst_ext;
      default:      prdata = '0;
    endcase
  end

  // global advance: pipeline moves when the output register is free
  logic adv;
  logic out_v;
  assign adv = !out_v || out_ch.ready;

  // input skid buffer, two words
  typedef struct packed {
    logic        action;
    logic [15:0] load_index;
    logic [31:0] load_pixel;
    logic [15:0] offset_x;
    logic [15:0] offset_y;
  } in_word_t;

  in_word_t skid [2];
  logic [1:0] skid_cnt;
  logic in_acc, pop;
  in_word_t head;

  assign in_ch.ready = (skid_cnt != 2'd2);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign head = (skid_cnt == 2'd0) ?
    {in_ch.action, in_ch.load_index, in_ch.load_pixel, in_ch.offset_x, in_ch.offset_y}
    : skid[0];
  assign pop = adv && (skid_cnt != 2'd0 || in_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_cnt <= '0;
    end else begin
      skid_cnt <= skid_cnt + {1'b0, in_acc} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      // head leaves; a word arriving behind a single held word takes its place
      if (skid_cnt == 2'd1 && in_acc)
        skid[0] <= {in_ch.action, in_ch.load_index, in_ch.load_pixel, in_ch.offset_x,
                    in_ch.offset_y};
      else
        skid[0] <= skid[1];
    end else if (in_acc) begin
      if (skid_cnt == 2'd0)
        skid[0] <= {in_ch.action, in_ch.load_index, in_ch.load_pixel, in_ch.offset_x,
                    in_ch.offset_y};
      else
        skid[1] <= {in_ch.action, in_ch.load_index, in_ch.load_pixel, in_ch.offset_x,
                    in_ch.offset_y};
    end
  end

  // front stage: rectangle checks
  logic [16:0] dxe, dye, cxe, cye;
  logic [2:0]  st_front;
  assign dxe = {1'b0, dst_org[15:0]} + {1'b0, dst_ext[15:0]};
  assign dye = {1'b0, dst_org[31:16]} + {1'b0, dst_ext[31:16]};
  assign cxe = {1'b0, crop_org[15:0]} + {1'b0, crop_ext[15:0]};
  assign cye = {1'b0, crop_org[31:16]} + {1'b0, crop_ext[31:16]};

  always_comb begin
    if (dst_ext[15:0] == 16'd0 || dst_ext[31:16] == 16'd0) st_front = ST_EMPTY;
    else if (dxe > {1'b0, dst_size[15:0]} || dye > {1'b0, dst_size[31:16]})
      st_front = ST_DEST;
    else if (crop_ext[15:0] == 16'd0 || crop_ext[31:16] == 16'd0) st_front = ST_EMPTY;
    else if (cxe > {1'b0, src_size[15:0]} || cye > {1'b0, src_size[31:16]})
      st_front = ST_CROP;
    else if (head.offset_x >= dst_ext[15:0] || head.offset_y >= dst_ext[31:16])
      st_front = ST_OFFSET;
    else st_front = ST_OK;
  end

  // pipeline payload carried alongside the divider
  typedef struct packed {
    logic        action;
    logic [2:0]  st;
    logic [15:0] load_index;
    logic [31:0] load_pixel;
    logic [15:0] ox;
    logic [15:0] oy;
  } pipe_t;

  logic  v [NS+1];
  pipe_t p [NS+1];
  // divider state per lane: dividend, remainder, quotient
  logic [DivW-1:0] nx [NS+1], ny [NS+1];
  logic [QW:0]     rx [NS+1], ry [NS+1];
  logic [QW-1:0]   qx [NS+1], qy [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= pop;
    end
  end

  // stage 0: register payload and front status, form products
  always_ff @(posedge clk) begin
    if (adv) begin
      p[0]  <= '{head.action, st_front, head.load_index, head.load_pixel,
                 head.offset_x, head.offset_y};
      nx[0] <= DivW'(head.offset_x) * DivW'(crop_ext[15:0]);
      ny[0] <= DivW'(head.offset_y) * DivW'(crop_ext[31:16]);
      rx[0] <= '0;
      ry[0] <= '0;
      qx[0] <= '0;
      qy[0] <= '0;
    end
  end

  // divider stages: each retires one quotient bit per lane. Quotient is
  // below 2^16 because offset < dest extent, so the top sixteen bits of the
  // 32-bit dividend seed the remainder in the first stage, as folded below.
  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_div
      logic [QW:0] trx, try_;
      logic [QW:0] sbx, sby;
      logic [QW+1:0] t2x, t2y;
      always_comb begin
        // the first stage folds in the top sixteen dividend bits, which
        // are below the divisor when the offset lies inside the dest extent
        if (gi == 0) begin
          trx = {1'b0, nx[gi][DivW-1:QW]};
          try_ = {1'b0, ny[gi][DivW-1:QW]};
        end else begin
          trx = rx[gi];
          try_ = ry[gi];
        end
        t2x = {trx, nx[gi][QW-1-gi]};
        t2y = {try_, ny[gi][QW-1-gi]};
        sbx = (t2x >= {2'b0, dst_ext[15:0]}) ?
              (QW+1)'(t2x - {2'b0, dst_ext[15:0]}) : t2x[QW:0];
        sby = (t2y >= {2'b0, dst_ext[31:16]}) ?
              (QW+1)'(t2y - {2'b0, dst_ext[31:16]}) : t2y[QW:0];
      end
      always_ff @(posedge clk) begin
        if (rst) v[gi+1] <= 1'b0;
        else if (adv) v[gi+1] <= v[gi];
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          p[gi+1]  <= p[gi];
          nx[gi+1] <= nx[gi];
          ny[gi+1] <= ny[gi];
          rx[gi+1] <= sbx;
          ry[gi+1] <= sby;
          qx[gi+1] <= {qx[gi][QW-2:0], (t2x >= {2'b0, dst_ext[15:0]})};
          qy[gi+1] <= {qy[gi][QW-2:0], (t2y >= {2'b0, dst_ext[31:16]})};
        end
      end
    end
  endgenerate

  // address stage
  logic        va;
  pipe_t       pa;
  logic [32:0] addr_a;
  logic [16:0] sx, sy;
  assign sx = {1'b0, crop_org[15:0]} + {1'b0, qx[NS]};
  assign sy = {1'b0, crop_org[31:16]} + {1'b0, qy[NS]};

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (adv) va <= v[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pa     <= p[NS];
      addr_a <= 33'(sy * {1'b0, src_size[15:0]}) + 33'(sx);
    end
  end

  // memory stage: load writes, blit reads
  logic [31:0] store [SOURCE_PIXELS];
  logic [31:0] rd_word;
  logic        vm;
  pipe_t       pm;
  logic        oob_m;

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (adv) vm <= va;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pm    <= pa;
      oob_m <= (addr_a >= 33'(SOURCE_PIXELS));
      if (va && !pa.action && 32'(pa.load_index) < 32'(SOURCE_PIXELS))
        store[AW'(pa.load_index)] <= pa.load_pixel;
      if (va && pa.action) rd_word <= store[addr_a[AW-1:0]];
    end
  end

  // convert stage to output register
  logic [2:0]  sc, dc;
  logic [7:0]  cr, cg, cb, ca;
  logic [31:0] pix;
  logic [2:0]  st_m;
  logic [31:0] idx_m;
  assign sc = clamp_comp(src_comp);
  assign dc = clamp_comp(dst_comp);
  assign cr = rd_word[7:0];
  assign cg = (sc <= 3'd2) ? cr : rd_word[15:8];
  assign cb = (sc <= 3'd2) ? cr : rd_word[23:16];
  assign ca = (sc == 3'd2) ? rd_word[15:8] : (sc == 3'd4) ? rd_word[31:24] : 8'hFF;
  assign st_m = (pm.st == ST_OK && oob_m) ? ST_CROP : pm.st;
  assign idx_m = 32'(({16'd0, dst_org[31:16]} + {16'd0, pm.oy}) * {16'd0, dst_size[15:0]})
               + {15'd0, {1'b0, dst_org[15:0]} + {1'b0, pm.ox}};

  always_comb begin
    case (dc)
      3'd1:    pix = {24'd0, cr};
      3'd2:    pix = {16'd0, ca, cr};
      3'd3:    pix = {8'd0, cb, cg, cr};
      default: pix = {ca, cb, cg, cr};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (adv) out_v <= vm;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!pm.action || st_m != ST_OK) begin
        out_ch.dest_index <= '0;
        out_ch.dest_pixel <= '0;
        out_ch.byte_count <= '0;
        out_ch.status     <= pm.action ? st_m : ST_OK;
      end else begin
        out_ch.dest_index <= idx_m;
        out_ch.dest_pixel <= pix;
        out_ch.byte_count <= dc;
        out_ch.status     <= ST_OK;
      end
    end
  end
  assign out_ch.valid = out_v;

  // assertions
  a_skid_bound: assert property (@(posedge clk) disable iff (rst) skid_cnt != 2'd3)
    else $error("skid overflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_v && !out_ch.ready |=> out_v && $stable(out_ch.dest_index))
    else $error("output dropped under stall");
  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    out_v && out_ch.byte_count == 3'd0 |-> out_ch.dest_pixel == 32'd0)
    else $error("pixel without byte count");
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    out_v && out_ch.status != ST_OK |-> out_ch.byte_count == 3'd0)
    else $error("bytes on error");
endmodule

// File: dv/tb_scaled_crop_blit.sv
`timescale 1ns / 1ps

module tb_scaled_crop_blit;
  import scb_pkg::*;

  localparam int STORE_WORDS = 65536;
  localparam int HANG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        action;
    logic [15:0] load_index;
    logic [31:0] load_pixel;
    logic [15:0] offset_x;
    logic [15:0] offset_y;
  } blit_word_t;

  typedef struct packed {
    logic [31:0] dest_index;
    logic [31:0] dest_pixel;
    logic [2:0]  byte_count;
    logic [2:0]  status;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  scb_in_if in_ch ();
  scb_out_if out_ch ();

  scaled_crop_blit uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [31:0] model_store [STORE_WORDS];
  logic [2:0]  m_src_comp = 3'd4, m_dst_comp = 3'd4;
  logic [31:0] m_src_size, m_dst_size, m_crop_org, m_crop_ext, m_dst_org, m_dst_ext;

  blit_word_t  pending_words[$];
  pixel_word_t expected_pixels[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          hold_off = 0;
  bit          stim_done = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [2:0] comp_fix(input logic [2:0] c);
    if (c == 3'd0) return 3'd1;
    if (c > 3'd4) return 3'd4;
    return c;
  endfunction

  // computes the result word for one accepted item and updates the store
  function automatic pixel_word_t blit_predict(input blit_word_t w);
    pixel_word_t r;
    logic [31:0] dw, dh, dx0, dy0, cw, ch, cx0, cy0, sw, ox, oy, sx, sy, addr, word;
    logic [7:0] cr, cg, cb, ca;
    logic [2:0] sc, dc;
    r = '0;
    if (!w.action) begin
      model_store[w.load_index] = w.load_pixel;
      return r;
    end
    dw = m_dst_ext[15:0]; dh = m_dst_ext[31:16];
    dx0 = m_dst_org[15:0]; dy0 = m_dst_org[31:16];
    cw = m_crop_ext[15:0]; ch = m_crop_ext[31:16];
    cx0 = m_crop_org[15:0]; cy0 = m_crop_org[31:16];
    sw = m_src_size[15:0];
    ox = w.offset_x; oy = w.offset_y;
    if (dw == 0 || dh == 0) r.status = ST_EMPTY;
    else if (dx0 + dw > m_dst_size[15:0] || dy0 + dh > m_dst_size[31:16]) r.status = ST_DEST;
    else if (cw == 0 || ch == 0) r.status = ST_EMPTY;
    else if (cx0 + cw > sw || cy0 + ch > m_src_size[31:16]) r.status = ST_CROP;
    else if (ox >= dw || oy >= dh) r.status = ST_OFFSET;
    if (r.status != ST_OK) return r;
    sx = cx0 + (ox * cw) / dw;
    sy = cy0 + (oy * ch) / dh;
    addr = sy * sw + sx;
    if (addr >= STORE_WORDS) begin
      r.status = ST_CROP;
      return r;
    end
    word = model_store[addr];
    sc = comp_fix(m_src_comp);
    cr = word[7:0];
    if (sc <= 3'd2) begin
      cg = cr; cb = cr;
      ca = (sc == 3'd2) ? word[15:8] : 8'hFF;
    end else begin
      cg = word[15:8]; cb = word[23:16];
      ca = (sc == 3'd4) ? word[31:24] : 8'hFF;
    end
    dc = comp_fix(m_dst_comp);
    case (dc)
      3'd1: r.dest_pixel = {24'd0, cr};
      3'd2: r.dest_pixel = {16'd0, ca, cr};
      3'd3: r.dest_pixel = {8'd0, cb, cg, cr};
      default: r.dest_pixel = {ca, cb, cg, cr};
    endcase
    r.byte_count = dc;
    r.dest_index = (dy0 + oy) * m_dst_size[15:0] + (dx0 + ox);
    return r;
  endfunction

  // driver: one word per handshake, random gap per word
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else begin
      if (in_ch.valid) send_gap = $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        blit_word_t w;
        w = pending_words.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= w.action;
        in_ch.load_index <= w.load_index;
        in_ch.load_pixel <= w.load_pixel;
        in_ch.offset_x <= w.offset_x;
        in_ch.offset_y <= w.offset_y;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    in_ch.action = 0; in_ch.load_index = 0; in_ch.load_pixel = 0;
    in_ch.offset_x = 0; in_ch.offset_y = 0;
  end

  // prediction at acceptance
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      expected_pixels.push_back(blit_predict({in_ch.action, in_ch.load_index,
          in_ch.load_pixel, in_ch.offset_x, in_ch.offset_y}));
  end

  // receiver stalls and result checking
  int recv_gap = 0;
  always @(posedge clk) begin
    pixel_word_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected word", out_ch.dest_index, 0);
        end else begin
          e = expected_pixels.pop_front();
          if (out_ch.dest_index !== e.dest_index) report("dest_index", out_ch.dest_index, e.dest_index);
          if (out_ch.dest_pixel !== e.dest_pixel) report("dest_pixel", out_ch.dest_pixel, e.dest_pixel);
          if (out_ch.byte_count !== e.byte_count) report("byte_count", out_ch.byte_count, e.byte_count);
          if (out_ch.status !== e.status) report("status", out_ch.status, e.status);
        end
        recv_gap = $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst || psel)
      idle_cycles <= 0;
    else if (pending_words.size() > 0 || expected_pixels.size() > 0 || !stim_done)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SRC_COMP: m_src_comp = value[2:0];
      REG_DST_COMP: m_dst_comp = value[2:0];
      REG_SRC_SIZE: m_src_size = value;
      REG_DST_SIZE: m_dst_size = value;
      REG_CROP_ORG: m_crop_org = value;
      REG_CROP_EXT: m_crop_ext = value;
      REG_DST_ORG:  m_dst_org = value;
      default:      m_dst_ext = value;
    endcase
  endtask

  // nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (pending_words.size() > 0 || in_ch.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic setup(input logic [2:0] sc, input logic [2:0] dc, input logic [31:0] ssz,
                       input logic [31:0] dsz, input logic [31:0] corg, input logic [31:0] cext,
                       input logic [31:0] dorg, input logic [31:0] dext);
    wait_idle();
    reg_write(REG_SRC_COMP, {29'd0, sc}); reg_write(REG_DST_COMP, {29'd0, dc});
    reg_write(REG_SRC_SIZE, ssz); reg_write(REG_DST_SIZE, dsz);
    reg_write(REG_CROP_ORG, corg); reg_write(REG_CROP_EXT, cext);
    reg_write(REG_DST_ORG, dorg); reg_write(REG_DST_EXT, dext);
  endtask

  function automatic blit_word_t load_word(input logic [15:0] idx, input logic [31:0] px);
    return {1'b0, idx, px, 16'($urandom), 16'($urandom)};
  endfunction

  function automatic blit_word_t blit_word(input logic [15:0] ox, input logic [15:0] oy);
    return {1'b1, 16'($urandom), 32'($urandom), ox, oy};
  endfunction

  // fill the whole source image so that every in-range read hits written data
  task automatic fill_source(input int pixels);
    for (int i = 0; i < pixels; i++) pending_words.push_back(load_word(16'(i), $urandom));
  endtask

  // random blits in a well-formed window, a few out of rect
  task automatic random_blits(input int n);
    logic [15:0] ox, oy;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        ox = 16'($urandom); oy = 16'($urandom);
      end else begin
        ox = 16'($urandom_range(0, m_dst_ext[15:0] - 1));
        oy = 16'($urandom_range(0, m_dst_ext[31:16] - 1));
      end
      pending_words.push_back(blit_word(ox, oy));
    end
  endtask

  initial begin
    logic [15:0] sw, sh, cw, ch, cx, cy, dw, dh;
    int row;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // error checks against reset registers
    pending_words.push_back(blit_word(0, 0));
    pending_words.push_back(load_word(16'hFFFF, 32'hFFFF_FFFF));
    pending_words.push_back(load_word(16'h0000, 32'h0000_0000));

    // empty, dest, crop-empty and crop statuses in check order
    setup(3'd4, 3'd4, 32'h0004_0004, 32'h0008_0008, 0, 32'h0004_0004, 0, 32'h0000_0004);
    pending_words.push_back(blit_word(0, 0));
    setup(3'd4, 3'd4, 32'h0004_0004, 32'h0008_0008, 0, 32'h0004_0004, 32'h0000_0006,
          32'h0004_0004);
    pending_words.push_back(blit_word(0, 0));
    setup(3'd4, 3'd4, 32'h0004_0004, 32'h0008_0008, 0, 32'h0004_0000, 0, 32'h0004_0004);
    pending_words.push_back(blit_word(0, 0));
    setup(3'd4, 3'd4, 32'h0004_0004, 32'h0008_0008, 32'h0001_0001, 32'h0004_0004, 0,
          32'h0004_0004);
    pending_words.push_back(blit_word(0, 0));
    // full 16-bit source: address beyond store, then an offset outside the dest
    setup(3'd4, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFF0_FFF0, 32'h000F_000F,
          32'hFFFE_FFFE, 32'h0001_0001);
    pending_words.push_back(blit_word(0, 0));
    pending_words.push_back(blit_word(16'hFFFF, 16'hFFFF));

    // every source code with dest codes 0, 3 and 6, including out-of-range codes
    setup(3'd4, 3'd4, 32'h0004_0004, 32'h0008_0008, 0, 32'h0004_0004, 32'h0002_0002,
          32'h0004_0004);
    fill_source(16);
    pending_words.push_back(blit_word(3, 3));
    pending_words.push_back(blit_word(4, 0));
    for (int s = 0; s < 8; s++)
      for (int d = 0; d < 8; d += 3) begin
        setup(3'(s), 3'(d), m_src_size, m_dst_size, m_crop_org, m_crop_ext, m_dst_org,
              m_dst_ext);
        pending_words.push_back(blit_word(16'($urandom_range(0, 3)),
                                          16'($urandom_range(0, 3))));
      end

    // random phases: small images mostly, one large
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 9) begin
        sw = 16'd256; sh = 16'd255;
      end else begin
        sw = 16'($urandom_range(1, 12)); sh = 16'($urandom_range(1, 12));
      end
      cw = 16'($urandom_range(1, sw)); ch = 16'($urandom_range(1, sh));
      cx = 16'($urandom_range(0, sw - cw)); cy = 16'($urandom_range(0, sh - ch));
      dw = 16'($urandom_range(1, 20)); dh = 16'($urandom_range(1, 20));
      if (phase == 0) begin
        cw = sw; ch = sh; cx = 0; cy = 0;
      end
      setup(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), {sh, sw},
            {16'(dh + $urandom_range(0, 30)), 16'(dw + $urandom_range(0, 30))},
            {cy, cx}, {ch, cw}, {16'($urandom_range(0, 5)), 16'($urandom_range(0, 5))},
            {dh, dw});
      // dest origin must keep rect inside image for ok results
      if (m_dst_org[15:0] + dw > m_dst_size[15:0] || m_dst_org[31:16] + dh > m_dst_size[31:16])
        reg_write(REG_DST_ORG, 0);
      if (phase == 9) begin
        // load only the crop columns that offsets 0 and dw-1 map to, in the rows that blits reach
        for (int oy2 = 0; oy2 < dh; oy2++) begin
          row = cy + (oy2 * ch) / dh;
          pending_words.push_back(load_word(16'(row * sw + cx), $urandom));
          pending_words.push_back(load_word(16'(row * sw + cx + ((dw - 1) * cw) / dw),
                                            $urandom));
        end
        wait_idle();
        // edge offsets map to loaded columns
        for (int i = 0; i < 20; i++)
          pending_words.push_back(blit_word(($urandom_range(0, 1)) ? dw - 16'd1 : 16'd0,
                                            16'($urandom_range(0, dh - 1))));
      end else begin
        fill_source(sw * sh);
        if (phase == 4) hold_off = 300;
        random_blits(30);
      end
    end

    wait_idle();
    stim_done = 1;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
